// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top level of the partition fit allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define ASSERT_SAME_CYCLE(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Check that cons holds in the cycle after ante holds.
`define ASSERT_NEXT_CYCLE(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- rtl/pfa_pkg.sv -----
// Package with types, constants and helpers of the partition fit allocator.
`default_nettype none

package pfa_pkg;

    // Default storage parameters
    localparam int unsigned DEF_PARTITIONS = 16;
    localparam int unsigned DEF_SIZE_BITS  = 16;

    // Fixed field widths
    localparam int unsigned IDX_W   = 4;
    localparam int unsigned SIZE_W  = 16;
    localparam int unsigned CNT_W   = 16;
    localparam int unsigned PCNT_W  = 5;
    localparam int unsigned POL_W   = 2;
    localparam int unsigned APB_AW  = 3;
    localparam int unsigned APB_DW  = 32;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Fit policy codes
    localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POL_W-1:0] POL_WORST = 2'd2;

    // Register indexes (byte address bit 2)
    localparam logic REG_FIT_POLICY = 1'b0;
    localparam logic REG_PART_COUNT = 1'b1;

    // Action codes
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_ALLOC = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [POL_W-1:0]  fit_policy;
        logic [PCNT_W-1:0] partition_count;
    } t_cfg;

    typedef struct packed {
        logic take_load;
        logic take_alloc;
        logic scan;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_sts;

    // Index width for a table of the given depth, at least one bit
    function automatic int unsigned f_idx_w(input int unsigned depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/pfa_if.sv -----
// Request and response channel interfaces of the partition fit allocator.
`default_nettype none

interface pfa_req_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [3:0]  partition_index;
    logic [15:0] size_value;

    modport source (output valid, output action, output partition_index,
                    output size_value, input ready);
    modport sink   (input valid, input action, input partition_index,
                    input size_value, output ready);
endinterface

interface pfa_rsp_if;
    logic        valid;
    logic        ready;
    logic        granted;
    logic [3:0]  partition_number;
    logic [15:0] remaining_space;
    logic [15:0] request_number;

    modport source (output valid, output granted, output partition_number,
                    output remaining_space, output request_number, input ready);
    modport sink   (input valid, input granted, input partition_number,
                    input remaining_space, input request_number, output ready);
endinterface

`default_nettype wire

// ----- rtl/pfa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pfa_ram
    import pfa_pkg::*;
#(
    parameter int unsigned WIDTH = DEF_SIZE_BITS,
    parameter int unsigned DEPTH = DEF_PARTITIONS
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [f_idx_w(DEPTH)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]            i_wdata,
    input  logic [f_idx_w(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and register the read word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/pfa_regs.sv -----
// APB configuration registers: fit policy and partition count.
`default_nettype none

module pfa_regs
    import pfa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    // Update the addressed register in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fit_policy      <= POL_FIRST;
            r_cfg.partition_count <= PCNT_W'(DEF_PARTITIONS);
        end else if (w_wr) begin
            unique case (paddr[2])
                REG_FIT_POLICY: r_cfg.fit_policy      <= pwdata[POL_W-1:0];
                REG_PART_COUNT: r_cfg.partition_count <= pwdata[PCNT_W-1:0];
                default:        r_cfg                 <= r_cfg;
            endcase
        end
    end

    // Return the addressed register
    always_comb begin
        unique case (paddr[2])
            REG_FIT_POLICY: prdata = APB_DW'(r_cfg.fit_policy);
            REG_PART_COUNT: prdata = APB_DW'(r_cfg.partition_count);
            default:        prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- rtl/pfa_ctrl.sv -----
// Controller state machine: accept, scan sequencing and result hand-off.
`default_nettype none

module pfa_ctrl
    import pfa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  logic i_req_action,
    output logic o_req_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_state = (i_req_action == ACT_ALLOC) ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb begin
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_req_ready      = 1'b1;
                o_cmd.take_load  = i_req_valid && (i_req_action == ACT_LOAD);
                o_cmd.take_alloc = i_req_valid && (i_req_action == ACT_ALLOC);
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            ST_DONE: begin
                o_cmd.finish = i_sts.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/pfa_dpath.sv -----
// Datapath: free-space store, sequential fit scan, counter and result register.
`default_nettype none

module pfa_dpath
    import pfa_pkg::*;
#(
    parameter int unsigned PARTITIONS = DEF_PARTITIONS,
    parameter int unsigned SIZE_BITS  = DEF_SIZE_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic [IDX_W-1:0]  i_partition_index,
    input  logic [SIZE_W-1:0] i_size_value,
    input  logic              i_rsp_ready,
    output logic              o_rsp_valid,
    output logic              o_granted,
    output logic [IDX_W-1:0]  o_partition_number,
    output logic [SIZE_W-1:0] o_remaining_space,
    output logic [CNT_W-1:0]  o_request_number
);

    localparam int unsigned AW = f_idx_w(PARTITIONS);
    localparam int unsigned IW = $clog2(PARTITIONS + 1);
    localparam int unsigned LW = (IW > PCNT_W) ? IW : PCNT_W;

    // Request state
    logic [SIZE_BITS-1:0]  r_size;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_is_load;
    logic [IDX_W-1:0]      r_ld_idx;
    // Scan state
    logic [IW-1:0]         r_idx;
    logic                  r_pend;
    logic [AW-1:0]         r_pend_idx;
    logic                  r_pend_vb;
    logic                  r_found;
    logic [AW-1:0]         r_pick;
    logic [SIZE_BITS-1:0]  r_best;
    logic [PARTITIONS-1:0] r_vld;
    // Result register
    logic                  r_out_vld;
    logic                  r_out_granted;
    logic [IDX_W-1:0]      r_out_pnum;
    logic [SIZE_W-1:0]     r_out_rem;
    logic [CNT_W-1:0]      r_out_reqn;

    logic [SIZE_BITS-1:0]  w_size_in;
    logic                  w_ld_hit;
    logic [LW-1:0]         w_cnt_ext;
    logic [LW-1:0]         w_lim;
    logic                  w_issue;
    logic [SIZE_BITS-1:0]  w_rdata;
    logic [SIZE_BITS-1:0]  w_sp;
    logic                  w_fits;
    logic                  w_take;
    logic [SIZE_BITS-1:0]  w_after;
    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [SIZE_BITS-1:0]  w_wdata;

    assign w_size_in = SIZE_BITS'(i_size_value);
    assign w_ld_hit  = (32'(i_partition_index) < PARTITIONS);

    // Clamp the searched range to the stored partitions
    assign w_cnt_ext = LW'(i_cfg.partition_count);
    assign w_lim     = (w_cnt_ext > LW'(PARTITIONS)) ? LW'(PARTITIONS) : w_cnt_ext;
    assign w_issue   = (LW'(r_idx) < w_lim);

    // Never-written entries read as zero
    assign w_sp   = r_pend_vb ? w_rdata : '0;
    assign w_fits = (w_sp >= r_size);

    // Apply the fit policy; strict compares keep the lowest index on ties
    always_comb begin
        case (i_cfg.fit_policy)
            POL_BEST:  w_take = w_fits && (!r_found || (w_sp < r_best));
            POL_WORST: w_take = w_fits && (!r_found || (w_sp > r_best));
            default:   w_take = w_fits && !r_found;
        endcase
    end

    assign w_after = r_best - r_size;

    // Write port: load items on accept, granted allocations on hand-off
    assign w_we    = (i_cmd.take_load && w_ld_hit) ||
                     (i_cmd.finish && !r_is_load && r_found);
    assign w_waddr = i_cmd.take_load ? AW'(i_partition_index) : r_pick;
    assign w_wdata = i_cmd.take_load ? w_size_in : w_after;

    pfa_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (PARTITIONS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // Mark written entries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_we) begin
            r_vld[w_waddr] <= 1'b1;
        end
    end

    // Capture requests and run the scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_is_load <= 1'b0;
            r_idx     <= '0;
            r_pend    <= 1'b0;
            r_found   <= 1'b0;
        end else if (i_cmd.take_load) begin
            r_cnt     <= '0;
            r_is_load <= 1'b1;
            r_ld_idx  <= i_partition_index;
            r_best    <= w_ld_hit ? w_size_in : '0;
            r_found   <= 1'b0;
            r_pend    <= 1'b0;
        end else if (i_cmd.take_alloc) begin
            if (r_cnt != CNT_MAX) begin
                r_cnt <= r_cnt + 1'b1;
            end
            r_is_load <= 1'b0;
            r_size    <= w_size_in;
            r_idx     <= '0;
            r_pend    <= 1'b0;
            r_found   <= 1'b0;
            r_pick    <= '0;
            r_best    <= '0;
        end else if (i_cmd.scan) begin
            // Issue the next read
            r_pend     <= w_issue;
            r_pend_idx <= r_idx[AW-1:0];
            r_pend_vb  <= r_vld[r_idx[AW-1:0]];
            if (w_issue) begin
                r_idx <= r_idx + 1'b1;
            end
            // Evaluate the word read last cycle
            if (r_pend && w_take) begin
                r_found <= 1'b1;
                r_pick  <= r_pend_idx;
                r_best  <= w_sp;
            end
        end
    end

    assign o_sts.scan_done = !w_issue && !r_pend;
    assign o_sts.out_free  = !r_out_vld || i_rsp_ready;

    // Result register: load on hand-off, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_vld <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_granted <= !r_is_load && r_found;
            r_out_reqn    <= r_cnt;
            if (r_is_load) begin
                r_out_pnum <= r_ld_idx;
                r_out_rem  <= SIZE_W'(r_best);
            end else if (r_found) begin
                r_out_pnum <= IDX_W'(r_pick);
                r_out_rem  <= SIZE_W'(w_after);
            end else begin
                r_out_pnum <= '0;
                r_out_rem  <= '0;
            end
        end
    end

    assign o_rsp_valid        = r_out_vld;
    assign o_granted          = r_out_granted;
    assign o_partition_number = r_out_pnum;
    assign o_remaining_space  = r_out_rem;
    assign o_request_number   = r_out_reqn;

endmodule

`default_nettype wire

// ----- rtl/partition_fit_allocator_top.sv -----
// Top level of the partition fit allocator.
//
//   Port         Dir     Protocol        Carries
//   i_req        in      valid/ready     action, partition_index, size_value
//   o_rsp        out     valid/ready     granted, partition_number,
//                                        remaining_space, request_number
//   psel..pready in/out  APB-style       fit_policy (0x0), partition_count (0x4)
//
// A load transaction is accepted, then its result is handed off. An allocate
// transaction is accepted, then scans N = min(partition_count, PARTITIONS) partitions
// one at a time through the single RAM read port, whose read data is registered,
// then closes the scan and hands off its result.
// Reset (synchronous, i_rst_n low) clears valid bits, counter and state at once.
// A held result stalls hand-off, and no new request is accepted until hand-off.
`default_nettype none

module partition_fit_allocator_top
    import pfa_pkg::*;
#(
    parameter int unsigned PARTITIONS = DEF_PARTITIONS,
    parameter int unsigned SIZE_BITS  = DEF_SIZE_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pfa_req_if.sink           i_req,
    pfa_rsp_if.source         o_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

`include "assert_macros.svh"

    t_cfg w_cfg;
    t_cmd w_cmd;
    t_sts w_sts;
    logic w_grant_shown;
    logic w_refusal_shown;
    logic w_refusal_clean;

    pfa_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    pfa_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req.valid),
        .i_req_action (i_req.action),
        .o_req_ready  (i_req.ready),
        .i_sts        (w_sts),
        .o_cmd        (w_cmd)
    );

    pfa_dpath #(
        .PARTITIONS (PARTITIONS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (w_cfg),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .i_partition_index  (i_req.partition_index),
        .i_size_value       (i_req.size_value),
        .i_rsp_ready        (o_rsp.ready),
        .o_rsp_valid        (o_rsp.valid),
        .o_granted          (o_rsp.granted),
        .o_partition_number (o_rsp.partition_number),
        .o_remaining_space  (o_rsp.remaining_space),
        .o_request_number   (o_rsp.request_number)
    );

    // Decode the presented result for the checks below
    assign w_grant_shown   = o_rsp.valid && o_rsp.granted;
    assign w_refusal_shown = o_rsp.valid && !o_rsp.granted && (o_rsp.request_number != 16'd0);
    assign w_refusal_clean = (o_rsp.partition_number == 4'd0) &&
                             (o_rsp.remaining_space == 16'd0);

    // Hand-off always presents a result next cycle
    `ASSERT_NEXT_CYCLE(a_finish_shows, i_clk, i_rst_n, w_cmd.finish, o_rsp.valid)

    // No request is taken while a scan runs
    `ASSERT_SAME_CYCLE(a_no_accept_in_scan, i_clk, i_rst_n, w_cmd.scan, !i_req.ready)

    // A grant always belongs to a counted request
    `ASSERT_SAME_CYCLE(a_grant_counted, i_clk, i_rst_n, w_grant_shown, o_rsp.request_number != 16'd0)

    // A refused request reports no partition and no space
    `ASSERT_SAME_CYCLE(a_refusal_clean, i_clk, i_rst_n, w_refusal_shown, w_refusal_clean)

endmodule

`default_nettype wire

// ----- sim/partition_fit_allocator_checker.sv -----
// Scoreboard for the partition fit allocator: predicts each result and compares it.
module partition_fit_allocator_checker
    import pfa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    pfa_req_if                i_req,
    pfa_rsp_if                i_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output int unsigned       o_failures,
    output int unsigned       o_pending,
    output int unsigned       o_checked,
    output int unsigned       o_granted
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic              granted;
        logic [IDX_W-1:0]  partition_number;
        logic [SIZE_W-1:0] remaining_space;
        logic [CNT_W-1:0]  request_number;
    } t_grant_result;

    // Shadow copy of the allocator state and its registers
    logic [SIZE_W-1:0] space_left [DEF_PARTITIONS];
    logic [CNT_W-1:0]  requests_since_load;
    logic [POL_W-1:0]  policy;
    logic [PCNT_W-1:0] search_count;

    t_grant_result expected_grants [$];

    // Apply one load or allocate transaction to the shadow state and return its result
    function automatic t_grant_result place_request(input logic act,
                                                    input logic [IDX_W-1:0] idx,
                                                    input logic [SIZE_W-1:0] req_size);
        t_grant_result res;
        int unsigned   scan_limit;
        int unsigned   j;
        int unsigned   pick;
        bit            found;
        res = '0;
        if (act == ACT_LOAD) begin
            space_left[idx]     = req_size;
            requests_since_load = '0;
            res.partition_number = idx;
            res.remaining_space  = req_size;
            return res;
        end
        if (requests_since_load != CNT_MAX) begin
            requests_since_load++;
        end
        scan_limit = (search_count > DEF_PARTITIONS) ? DEF_PARTITIONS : search_count;
        found = 1'b0;
        pick  = 0;
        for (j = 0; j < scan_limit; j++) begin
            if (space_left[j] < req_size) begin
                continue;
            end
            if (!found) begin
                found = 1'b1;
                pick  = j;
                // first fit and the unused code stop at the lowest fitting index
                if (policy != POL_BEST && policy != POL_WORST) begin
                    break;
                end
            end else if (policy == POL_BEST && space_left[j] < space_left[pick]) begin
                pick = j;
            end else if (policy == POL_WORST && space_left[j] > space_left[pick]) begin
                pick = j;
            end
        end
        if (found) begin
            space_left[pick]     = space_left[pick] - req_size;
            res.granted          = 1'b1;
            res.partition_number = pick[IDX_W-1:0];
            res.remaining_space  = space_left[pick];
        end
        res.request_number = requests_since_load;
        return res;
    endfunction

    task automatic compare_field(input string name, input logic [SIZE_W-1:0] want,
                                 input logic [SIZE_W-1:0] got);
        if (want !== got) begin
            o_failures++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Check results, then predict new transactions, then track register writes
    always @(posedge i_clk) begin
        t_grant_result want;
        if (!i_rst_n) begin
            expected_grants.delete();
            for (int k = 0; k < DEF_PARTITIONS; k++) begin
                space_left[k] = '0;
            end
            requests_since_load = '0;
            policy       = POL_FIRST;
            search_count = PCNT_W'(DEF_PARTITIONS);
            o_failures   = 0;
            o_checked    = 0;
            o_granted    = 0;
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                o_checked++;
                if (expected_grants.size() == 0) begin
                    o_failures++;
                    $display("%0t: result with nothing expected: granted %0b partition %0d remaining %0d request %0d",
                             $time, i_rsp.granted, i_rsp.partition_number,
                             i_rsp.remaining_space, i_rsp.request_number);
                end else begin
                    want = expected_grants.pop_front();
                    if (want.granted) begin
                        o_granted++;
                    end
                    compare_field("granted", SIZE_W'(want.granted), SIZE_W'(i_rsp.granted));
                    compare_field("partition_number", SIZE_W'(want.partition_number),
                                  SIZE_W'(i_rsp.partition_number));
                    compare_field("remaining_space", want.remaining_space,
                                  i_rsp.remaining_space);
                    compare_field("request_number", want.request_number,
                                  i_rsp.request_number);
                end
            end
            if (i_req.valid && i_req.ready) begin
                expected_grants.push_back(place_request(i_req.action, i_req.partition_index,
                                                        i_req.size_value));
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[2])
                    REG_FIT_POLICY: begin
                        policy = pwdata[POL_W-1:0];
                    end
                    REG_PART_COUNT: begin
                        search_count = pwdata[PCNT_W-1:0];
                    end
                endcase
            end
        end
        o_pending = expected_grants.size();
    end

endmodule

// ----- sim/partition_fit_allocator_top_tb.sv -----
// Testbench top for the partition fit allocator: clock, reset, stimulus and verdict.
module partition_fit_allocator_top_tb;
    import pfa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [APB_AW-1:0] ADDR_FIT_POLICY = {REG_FIT_POLICY, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_PART_COUNT = {REG_PART_COUNT, 2'b00};
    localparam logic [POL_W-1:0]  POL_UNUSED      = 2'd3;
    localparam int unsigned       CYCLE_LIMIT     = 2_000_000;
    localparam int unsigned       SETTLE_CYCLES   = DEF_PARTITIONS + 8;
    localparam int unsigned       LONG_HOLD       = 300;
    localparam int unsigned       RANDOM_PHASES   = 7;
    localparam int unsigned       PHASE_ITEMS     = 150;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    pfa_req_if req_ch ();
    pfa_rsp_if rsp_ch ();

    int unsigned failures;
    int unsigned pending;
    int unsigned checked;
    int unsigned grants;
    int unsigned items_sent = 0;
    int unsigned cycle_count = 0;
    bit          tx_steady = 1'b0;
    bit          rx_steady = 1'b0;
    bit          rx_long_hold = 1'b0;

    partition_fit_allocator_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    partition_fit_allocator_checker fit_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .i_rsp      (rsp_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .o_failures (failures),
        .o_pending  (pending),
        .o_checked  (checked),
        .o_granted  (grants)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones, none in steady stretches
    function automatic int unsigned pick_gap(input bit steady);
        int unsigned roll;
        if (steady) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 85) begin
            return $urandom_range(1, 3);
        end else if (roll < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Result receiver: random back-pressure, plus one long hold on request
    initial begin
        int unsigned stall_left;
        stall_left   = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_long_hold) begin
                stall_left   = LONG_HOLD;
                rx_long_hold = 1'b0;
            end
            if (stall_left > 0) begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                rsp_ch.ready <= 1'b1;
                stall_left = pick_gap(rx_steady);
            end
        end
    end

    // Offer one transaction and hold it until accepted; starts and ends at a falling edge
    task automatic send_item(input logic act, input logic [IDX_W-1:0] idx,
                             input logic [SIZE_W-1:0] req_size);
        int unsigned gap;
        req_ch.valid           <= 1'b1;
        req_ch.action          <= act;
        req_ch.partition_index <= idx;
        req_ch.size_value      <= req_size;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
        items_sent++;
        gap = pick_gap(tx_steady);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic send_random_item(input int unsigned load_pct);
        logic [SIZE_W-1:0] req_size;
        int unsigned       roll;
        roll = $urandom_range(0, 99);
        if (roll < load_pct) begin
            roll = $urandom_range(0, 99);
            if (roll < 40) begin
                req_size = SIZE_W'($urandom_range(0, 20000));
            end else if (roll < 60) begin
                req_size = SIZE_W'($urandom);
            end else if (roll < 70) begin
                req_size = '1;
            end else if (roll < 80) begin
                req_size = '0;
            end else begin
                req_size = SIZE_W'($urandom_range(0, 300));
            end
            send_item(ACT_LOAD, IDX_W'($urandom_range(0, DEF_PARTITIONS - 1)), req_size);
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 50) begin
                req_size = SIZE_W'($urandom_range(0, 2000));
            end else if (roll < 70) begin
                req_size = SIZE_W'($urandom_range(0, 300));
            end else if (roll < 85) begin
                req_size = SIZE_W'($urandom);
            end else if (roll < 95) begin
                req_size = '0;
            end else begin
                req_size = '1;
            end
            // the index is ignored on allocate; randomize it anyway
            send_item(ACT_ALLOC, IDX_W'($urandom), req_size);
        end
    endtask

    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // Drain all outstanding results, let the block settle, then reprogram it
    task automatic set_fit_config(input logic [POL_W-1:0] pol, input logic [PCNT_W-1:0] count);
        req_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        apb_write(ADDR_FIT_POLICY, APB_DW'(pol));
        apb_write(ADDR_PART_COUNT, APB_DW'(count));
    endtask

    initial begin
        logic [POL_W-1:0]  pol;
        logic [PCNT_W-1:0] count;
        int unsigned       roll;
        int unsigned       preload;

        // Known values on every input before and during reset
        i_rst_n                = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        req_ch.valid           = 1'b0;
        req_ch.action          = ACT_LOAD;
        req_ch.partition_index = '0;
        req_ch.size_value      = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty store, zero-size request, refusal
        send_item(ACT_ALLOC, 4'd0, 16'd0);
        send_item(ACT_ALLOC, 4'd15, 16'd1);
        send_item(ACT_LOAD, 4'd0, 16'hFFFF);
        send_item(ACT_LOAD, 4'd15, 16'h8000);
        send_item(ACT_LOAD, 4'd5, 16'd300);
        send_item(ACT_LOAD, 4'd9, 16'd300);
        send_item(ACT_LOAD, 4'd3, 16'd1000);
        send_item(ACT_ALLOC, 4'd0, 16'hFFFF);
        send_item(ACT_ALLOC, 4'd0, 16'd100);
        // Best fit with a tie, then an exact fit
        set_fit_config(POL_BEST, PCNT_W'(DEF_PARTITIONS));
        send_item(ACT_ALLOC, 4'd0, 16'd250);
        send_item(ACT_ALLOC, 4'd0, 16'd300);
        // Worst fit, zero-size request on the largest partition
        set_fit_config(POL_WORST, PCNT_W'(DEF_PARTITIONS));
        send_item(ACT_ALLOC, 4'd0, 16'd10);
        send_item(ACT_ALLOC, 4'd0, 16'd0);
        // Unused policy code acts as first fit
        set_fit_config(POL_UNUSED, PCNT_W'(DEF_PARTITIONS));
        send_item(ACT_ALLOC, 4'd0, 16'd40);
        // Nothing searched
        set_fit_config(POL_FIRST, '0);
        send_item(ACT_ALLOC, 4'd0, 16'd0);
        // Single partition searched
        set_fit_config(POL_WORST, PCNT_W'(1));
        send_item(ACT_ALLOC, 4'd0, 16'd0);
        send_item(ACT_ALLOC, 4'd0, 16'd1);
        // Counts above the partition total clip to it
        set_fit_config(POL_BEST, '1);
        send_item(ACT_ALLOC, 4'd0, 16'd20);
        set_fit_config(POL_BEST, PCNT_W'(DEF_PARTITIONS + 1));
        send_item(ACT_LOAD, 4'd15, 16'hFFFF);
        send_item(ACT_ALLOC, 4'd0, 16'h8000);

        // Random phases: preload some partitions, then mostly allocate
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            pol  = POL_W'($urandom_range(0, 3));
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
                count = '0;
            end else if (roll < 20) begin
                count = PCNT_W'(1);
            end else if (roll < 60) begin
                count = PCNT_W'(DEF_PARTITIONS);
            end else if (roll < 85) begin
                count = PCNT_W'($urandom_range(2, DEF_PARTITIONS - 1));
            end else begin
                count = PCNT_W'($urandom_range(DEF_PARTITIONS + 1, 31));
            end
            set_fit_config(pol, count);
            tx_steady = (phase == 2);
            rx_steady = (phase == 5);
            // Stall the output long enough to back up the input
            if (phase == 3) begin
                rx_long_hold = 1'b1;
            end
            preload = $urandom_range(4, DEF_PARTITIONS);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                send_random_item((k < preload) ? 100 : 20);
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;

        // Drain and report
        req_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        $display("tb: %0d transactions sent, %0d results checked, %0d granted",
                 items_sent, checked, grants);
        $display("tb: covered all fit policies, counts from zero to above the total, hold-off");
        if (failures == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
